// ===== design/hfs_pkg.sv =====
// Shared constants for the harmonic frequency sampler.
package hfs_pkg;

    localparam int DEF_MAX_POP   = 512;
    localparam int DEF_FRAC_BITS = 32;
    localparam int POP_W         = 10;
    localparam int IN_W          = 32;
    localparam int CDF_W         = 32;
    localparam int COUNT_W       = 10;
    localparam int FREQ_W        = 16;
    localparam int OUT_W         = 32;
    localparam int STEP_W        = 6;

endpackage

// ===== design/hfs_ram.sv =====
// Generic simple dual-port RAM with registered read data.
module hfs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== design/hfs_div.sv =====
// Bit-serial restoring divider: floor(num * 2^steps / den) for num < den.
module hfs_div #(
    parameter int NW = 40,
    parameter int QW = 32
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [NW-1:0]             num,
    input  logic [NW-1:0]             den,
    input  logic [hfs_pkg::STEP_W-1:0] steps,
    output logic                      busy,
    output logic                      done,
    output logic [QW-1:0]             quot
);

    logic [NW-1:0]              rem_reg, rem_next;
    logic [NW-1:0]              den_reg, den_next;
    logic [QW-1:0]              quot_reg, quot_next;
    logic [hfs_pkg::STEP_W-1:0] cnt_reg, cnt_next;
    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;
    logic [NW:0]                rem2;
    logic [NW:0]                rem_sub;
    logic                       ge;

    assign rem2    = {rem_reg, 1'b0};
    assign rem_sub = rem2 - {1'b0, den_reg};
    assign ge      = rem2 >= {1'b0, den_reg};

    always_comb
    begin
        rem_next  = rem_reg;
        den_next  = den_reg;
        quot_next = quot_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = num;
            den_next  = den;
            quot_next = '0;
            cnt_next  = steps;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next  = ge ? rem_sub[NW-1:0] : rem2[NW-1:0];
            quot_next = {quot_reg[QW-2:0], ge};
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == hfs_pkg::STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        quot_reg <= quot_next;
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quot = quot_reg;

endmodule

// ===== design/harmonic_frequency_sampler.sv =====
// Harmonic frequency sampler: neutral site-frequency draw by table lookup.
//
// After reset or a write of pop_size, the first item triggers a table build: two
// passes over counts 1..2N-1 through one shared bit-serial divider, first to sum
// the harmonic total, then to write each cumulative Q0.32 entry into the table
// RAM. With the table built, an item is accepted, then goes through a binary
// search of one RAM read per cycle, a 16-step divide for the frequency (skipped,
// with count and frequency 0, when the search ends past the table), and a load
// of the output register once that register is free. One item is in work at a
// time; the output register lets the next item be taken while a result waits.
module harmonic_frequency_sampler #(
    parameter int MAX_POP   = hfs_pkg::DEF_MAX_POP,
    parameter int FRAC_BITS = hfs_pkg::DEF_FRAC_BITS
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [hfs_pkg::POP_W-1:0]  cfg_data,       // pop_size
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [hfs_pkg::IN_W-1:0]   s_axis_tdata,   // [31:0] uniform_sample
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [hfs_pkg::OUT_W-1:0]  m_axis_tdata    // [9:0] allele_count,
                                                       // [25:10] frequency, rest 0
);

    localparam int DEPTH = 2 * MAX_POP;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int IW    = AW + 1;
    localparam int HW    = FRAC_BITS + 8;
    localparam int QW    = (FRAC_BITS > hfs_pkg::CDF_W) ? FRAC_BITS : hfs_pkg::CDF_W;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_TERM  = 9'b000000010,
        S_TWAIT = 9'b000000100,
        S_ACC   = 9'b000001000,
        S_CDF   = 9'b000010000,
        S_CWAIT = 9'b000100000,
        S_SRCH  = 9'b001000000,
        S_FWAIT = 9'b010000000,
        S_OUT   = 9'b100000000
    } state_t;

    state_t                        state_reg, state_next;
    logic [hfs_pkg::POP_W-1:0]     pop_reg, pop_next;
    logic                          valid_reg, valid_next;
    logic                          pass2_reg, pass2_next;
    logic [IW-1:0]                 idx_reg, idx_next;
    logic [HW-1:0]                 sum_reg, sum_next;
    logic [HW-1:0]                 total_reg, total_next;
    logic [HW-1:0]                 term_reg, term_next;
    logic [hfs_pkg::IN_W-1:0]      u_reg, u_next;
    logic [IW-1:0]                 lo_reg, lo_next;
    logic [IW-1:0]                 hi_reg, hi_next;
    logic [IW-1:0]                 count_reg, count_next;
    logic                          ovalid_reg, ovalid_next;
    logic [hfs_pkg::COUNT_W-1:0]   ocount_reg, ocount_next;
    logic [hfs_pkg::FREQ_W-1:0]    ofreq_reg, ofreq_next;
    logic [hfs_pkg::FREQ_W-1:0]    freq_reg, freq_next;

    logic [31:0]                   eff_pop;
    logic [IW-1:0]                 two_n;
    logic [IW-1:0]                 last_idx;
    logic [HW-1:0]                 one_q;
    logic [HW-1:0]                 acc_sum;
    logic [IW:0]                   mid_wide;
    logic [IW-1:0]                 lo_s, hi_s;
    logic                          take_in;

    logic                          div_start, div_busy, div_done;
    logic [HW-1:0]                 div_num, div_den;
    logic [hfs_pkg::STEP_W-1:0]    div_steps;
    logic [QW-1:0]                 div_quot;

    logic                          ram_we;
    logic [AW-1:0]                 ram_raddr;
    logic [hfs_pkg::CDF_W-1:0]     ram_wdata, ram_rdata;

    assign eff_pop  = (pop_reg == '0) ? 32'd1 :
                      ((32'(pop_reg) > 32'(MAX_POP)) ? 32'(MAX_POP) : 32'(pop_reg));
    assign two_n    = IW'(eff_pop << 1);
    assign last_idx = two_n - 1'b1;
    assign one_q    = HW'(1) << FRAC_BITS;
    assign acc_sum  = sum_reg + term_reg;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = (state_reg == S_IDLE) && valid_reg;
    assign take_in       = s_axis_tvalid && s_axis_tready;

    // Search step: the read issued last cycle returns now.
    always_comb
    begin
        lo_s = lo_reg;
        hi_s = hi_reg;
        if (state_reg == S_SRCH)
        begin
            if (ram_rdata >= u_reg)
            begin
                hi_s = mid_wide[IW-1:0];
            end
            else
            begin
                lo_s = mid_wide[IW-1:0] + 1'b1;
            end
        end
    end

    assign mid_wide = ({1'b0, lo_reg} + {1'b0, hi_reg}) >> 1;

    always_comb
    begin
        if (state_reg == S_SRCH)
        begin
            ram_raddr = AW'(({1'b0, lo_s} + {1'b0, hi_s}) >> 1);
        end
        else
        begin
            ram_raddr = AW'(({1'b0, IW'(1)} + {1'b0, two_n}) >> 1);
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        pop_next    = pop_reg;
        valid_next  = valid_reg;
        pass2_next  = pass2_reg;
        idx_next    = idx_reg;
        sum_next    = sum_reg;
        total_next  = total_reg;
        term_next   = term_reg;
        u_next      = u_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        count_next  = count_reg;
        freq_next   = freq_reg;
        ovalid_next = ovalid_reg;
        ocount_next = ocount_reg;
        ofreq_next  = ofreq_reg;
        div_start   = 1'b0;
        div_num     = sum_reg;
        div_den     = total_reg;
        div_steps   = hfs_pkg::STEP_W'(hfs_pkg::CDF_W);
        ram_we      = 1'b0;
        ram_wdata   = div_quot[hfs_pkg::CDF_W-1:0];

        if (m_axis_tready)
        begin
            ovalid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (take_in)
                begin
                    u_next     = s_axis_tdata;
                    lo_next    = IW'(1);
                    hi_next    = two_n;
                    state_next = S_SRCH;
                end
                else if (s_axis_tvalid && !valid_reg)
                begin
                    idx_next   = IW'(1);
                    sum_next   = '0;
                    pass2_next = 1'b0;
                    state_next = S_TERM;
                end
            end
            S_TERM:
            begin
                if (idx_reg == IW'(1))
                begin
                    term_next  = one_q;
                    state_next = S_ACC;
                end
                else
                begin
                    div_start  = 1'b1;
                    div_num    = HW'(1);
                    div_den    = HW'(idx_reg);
                    div_steps  = hfs_pkg::STEP_W'(FRAC_BITS);
                    state_next = S_TWAIT;
                end
            end
            S_TWAIT:
            begin
                if (div_done)
                begin
                    term_next  = HW'(div_quot[FRAC_BITS-1:0]);
                    state_next = S_ACC;
                end
            end
            S_ACC:
            begin
                sum_next = acc_sum;
                if (pass2_reg)
                begin
                    state_next = S_CDF;
                end
                else if (idx_reg == last_idx)
                begin
                    total_next = acc_sum;
                    pass2_next = 1'b1;
                    idx_next   = IW'(1);
                    sum_next   = '0;
                    state_next = S_TERM;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_TERM;
                end
            end
            S_CDF:
            begin
                if (sum_reg >= total_reg)
                begin
                    // Saturate the entry that reaches the full total.
                    ram_we    = 1'b1;
                    ram_wdata = '1;
                    if (idx_reg == last_idx)
                    begin
                        valid_next = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = S_TERM;
                    end
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = S_CWAIT;
                end
            end
            S_CWAIT:
            begin
                if (div_done)
                begin
                    ram_we = 1'b1;
                    if (idx_reg == last_idx)
                    begin
                        valid_next = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = S_TERM;
                    end
                end
            end
            S_SRCH:
            begin
                lo_next = lo_s;
                hi_next = hi_s;
                if (lo_s >= hi_s)
                begin
                    if (lo_s == two_n)
                    begin
                        count_next = '0;
                        freq_next  = '0;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        count_next = lo_s;
                        div_start  = 1'b1;
                        div_num    = HW'(lo_s);
                        div_den    = HW'(two_n);
                        div_steps  = hfs_pkg::STEP_W'(hfs_pkg::FREQ_W);
                        state_next = S_FWAIT;
                    end
                end
            end
            S_FWAIT:
            begin
                if (div_done)
                begin
                    freq_next  = div_quot[hfs_pkg::FREQ_W-1:0];
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!ovalid_reg || m_axis_tready)
                begin
                    ovalid_next = 1'b1;
                    ocount_next = hfs_pkg::COUNT_W'(count_reg);
                    ofreq_next  = freq_reg;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg_valid && cfg_ready)
        begin
            pop_next   = cfg_data;
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            pop_reg    <= hfs_pkg::POP_W'(512);
            valid_reg  <= 1'b0;
            pass2_reg  <= 1'b0;
            total_reg  <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            pop_reg    <= pop_next;
            valid_reg  <= valid_next;
            pass2_reg  <= pass2_next;
            total_reg  <= total_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        sum_reg    <= sum_next;
        term_reg   <= term_next;
        u_reg      <= u_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        count_reg  <= count_next;
        freq_reg   <= freq_next;
        ocount_reg <= ocount_next;
        ofreq_reg  <= ofreq_next;
    end

    hfs_div #(
        .NW (HW),
        .QW (QW)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .steps (div_steps),
        .busy  (div_busy),
        .done  (div_done),
        .quot  (div_quot)
    );

    hfs_ram #(
        .WIDTH (hfs_pkg::CDF_W),
        .DEPTH (DEPTH)
    ) u_cdf_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (idx_reg[AW-1:0]),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = {{(hfs_pkg::OUT_W - hfs_pkg::COUNT_W - hfs_pkg::FREQ_W){1'b0}},
                            ofreq_reg, ocount_reg};

    a_div_idle_on_start: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_busy)
        else $error("divider started while busy");

    a_write_only_in_build: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> !valid_reg && pass2_reg)
        else $error("table written outside the second build pass");

    a_search_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SRCH) |-> (lo_reg < hi_reg) && (hi_reg <= two_n))
        else $error("search window out of bounds");

    a_accept_needs_table: assert property (@(posedge clk) disable iff (!rst_n)
        take_in |=> (state_reg == S_SRCH) && valid_reg)
        else $error("item accepted without a built table");

endmodule
